// ----- src/ofip_pkg.sv -----
// Shared constants and record types for the OBJ face index parser.
package ofip_pkg;

  localparam int INDEX_BITS_DEF  = 24;
  localparam int MAX_CORNERS_DEF = 255;

  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 24;
  localparam int OUT_IDX_W = 24;
  localparam int CC_W      = 8;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_CORNER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END_OK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_ERR = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [OUT_IDX_W-1:0] pos_index;
    logic [OUT_IDX_W-1:0] tex_index;
    logic [OUT_IDX_W-1:0] norm_index;
    logic [OUT_IDX_W-1:0] first_pos_index;
    logic [CC_W-1:0]      corner_count;
    logic                 last;
  } res_t;

  // Which of the two result slots an accepted character fills.
  typedef struct packed {
    logic rec0;
    logic rec1;
  } push_t;

endpackage

// ----- src/ofip_if.sv -----
// Valid/ready channel interfaces for the character input and the record output.
interface ofip_in_if import ofip_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_in;
  logic [COUNT_W-1:0] position_count;
  logic [COUNT_W-1:0] texcoord_count;
  logic [COUNT_W-1:0] normal_count;

  modport source (output valid, output char_in, output position_count,
                  output texcoord_count, output normal_count, input ready);
  modport sink   (input valid, input char_in, input position_count,
                  input texcoord_count, input normal_count, output ready);
endinterface

interface ofip_out_if import ofip_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [OUT_IDX_W-1:0] pos_index;
  logic [OUT_IDX_W-1:0] tex_index;
  logic [OUT_IDX_W-1:0] norm_index;
  logic [OUT_IDX_W-1:0] first_pos_index;
  logic [CC_W-1:0]      corner_count;
  logic                 last;

  modport source (output valid, output kind, output pos_index, output tex_index,
                  output norm_index, output first_pos_index, output corner_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input pos_index, input tex_index,
                  input norm_index, input first_pos_index, input corner_count,
                  input last, output ready);
endinterface

// ----- src/ofip_parse.sv -----
// Per-character face parser: field phase, number accumulator and corner records.
module ofip_parse import ofip_pkg::*; #(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [CHAR_W-1:0]  char_in,
  input  logic [COUNT_W-1:0] position_count,
  input  logic [COUNT_W-1:0] texcoord_count,
  input  logic [COUNT_W-1:0] normal_count,
  output res_t               rec0,
  output res_t               rec1,
  output push_t              push
);

  localparam int CNT_W = $clog2(MAX_CORNERS + 1);

  localparam logic [2:0] PH_POS_WAIT  = 3'd0;
  localparam logic [2:0] PH_POS_NUM   = 3'd1;
  localparam logic [2:0] PH_SLASH     = 3'd2;
  localparam logic [2:0] PH_TEX_NUM   = 3'd3;
  localparam logic [2:0] PH_NORM_WAIT = 3'd4;
  localparam logic [2:0] PH_NORM_NUM  = 3'd5;
  localparam logic [2:0] PH_ERR       = 3'd6;

  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  logic [2:0]            phase_r,     phase_nxt;
  logic [INDEX_BITS-1:0] accum_r,     accum_nxt;
  logic                  neg_r,       neg_nxt;
  logic                  seen_r,      seen_nxt;
  logic [INDEX_BITS-1:0] cur_pos_r,   cur_pos_nxt;
  logic [INDEX_BITS-1:0] cur_tex_r,   cur_tex_nxt;
  logic [INDEX_BITS-1:0] cur_norm_r,  cur_norm_nxt;
  logic [INDEX_BITS-1:0] first_pos_r, first_pos_nxt;
  logic [CNT_W-1:0]      corners_r,   corners_nxt;
  logic                  err_r,       err_nxt;

  logic                  is_dig, is_blank, is_sign, is_nl, is_slash;
  logic [INDEX_BITS-1:0] dig_val, acc_add;
  logic [31:0]           pc_w, tc_w, nc_w;
  logic [INDEX_BITS-1:0] res_pos, res_tex, res_norm;
  logic                  corner_done, run_pw, do_fail, do_end;
  res_t                  corner_rec, end_rec;

  function automatic logic [INDEX_BITS-1:0] resolve(input logic [INDEX_BITS-1:0] acc,
                                                    input logic                  neg,
                                                    input logic [INDEX_BITS-1:0] cnt);
    if (acc == '0) return '0;
    if (neg) return cnt - acc;
    return acc - 1'b1;
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out(input logic [INDEX_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OUT_IDX_W-1:0];
  endfunction

  function automatic logic [CC_W-1:0] to_cc(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[CC_W-1:0];
  endfunction

  assign is_dig   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_CR) ||
                    (char_in == CH_VT) || (char_in == CH_FF);
  assign is_sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);
  assign is_nl    = (char_in == CH_NL);
  assign is_slash = (char_in == CH_SLASH);

  // The low nibble of an ASCII digit is its value.
  assign dig_val = INDEX_BITS'(char_in[3:0]);
  assign acc_add = (accum_r << 3) + (accum_r << 1) + dig_val;

  assign pc_w = 32'(position_count);
  assign tc_w = 32'(texcoord_count);
  assign nc_w = 32'(normal_count);

  assign res_pos  = resolve(accum_r, neg_r, pc_w[INDEX_BITS-1:0]);
  assign res_tex  = resolve(accum_r, neg_r, tc_w[INDEX_BITS-1:0]);
  assign res_norm = resolve(accum_r, neg_r, nc_w[INDEX_BITS-1:0]);

  always_comb begin
    phase_nxt     = phase_r;
    accum_nxt     = accum_r;
    neg_nxt       = neg_r;
    seen_nxt      = seen_r;
    cur_pos_nxt   = cur_pos_r;
    cur_tex_nxt   = cur_tex_r;
    cur_norm_nxt  = cur_norm_r;
    first_pos_nxt = first_pos_r;
    corners_nxt   = corners_r;
    err_nxt       = err_r;
    corner_done   = 1'b0;
    run_pw        = 1'b0;
    do_fail       = 1'b0;
    do_end        = 1'b0;
    corner_rec    = '0;
    end_rec       = '0;

    case (phase_r)
      PH_POS_WAIT: begin
        run_pw = 1'b1;
      end
      PH_POS_NUM: begin
        if (is_dig) begin
          accum_nxt = acc_add;
          seen_nxt  = 1'b1;
        end else if (!seen_r) begin
          do_fail = 1'b1;
        end else begin
          cur_pos_nxt = res_pos;
          if (is_slash) phase_nxt = PH_SLASH;
          else corner_done = 1'b1;
        end
      end
      PH_SLASH: begin
        if (is_dig) begin
          neg_nxt   = 1'b0;
          seen_nxt  = 1'b1;
          accum_nxt = dig_val;
          phase_nxt = PH_TEX_NUM;
        end else if (is_slash) begin
          phase_nxt = PH_NORM_WAIT;
        end else begin
          corner_done = 1'b1;
        end
      end
      PH_TEX_NUM: begin
        if (is_dig) begin
          accum_nxt = acc_add;
        end else begin
          cur_tex_nxt = res_tex;
          if (is_slash) phase_nxt = PH_NORM_WAIT;
          else corner_done = 1'b1;
        end
      end
      PH_NORM_WAIT: begin
        if (is_sign || is_dig) begin
          neg_nxt   = (char_in == CH_MINUS);
          seen_nxt  = is_dig;
          accum_nxt = is_dig ? dig_val : '0;
          phase_nxt = PH_NORM_NUM;
        end else if (!is_blank) begin
          do_fail = 1'b1;
        end
      end
      PH_NORM_NUM: begin
        if (is_dig) begin
          accum_nxt = acc_add;
          seen_nxt  = 1'b1;
        end else if (!seen_r) begin
          do_fail = 1'b1;
        end else begin
          cur_norm_nxt = res_norm;
          corner_done  = 1'b1;
        end
      end
      default: begin
        err_nxt = 1'b1;
        do_end  = is_nl;
      end
    endcase

    // Emit the finished corner, then treat the terminator as the start of a new one.
    if (corner_done) begin
      if (corners_r == '0) first_pos_nxt = cur_pos_nxt;
      if (32'(corners_r) < MAX_CORNERS) corners_nxt = corners_r + 1'b1;
      corner_rec.kind            = KIND_CORNER;
      corner_rec.pos_index       = to_out(cur_pos_nxt);
      corner_rec.tex_index       = to_out(cur_tex_nxt);
      corner_rec.norm_index      = to_out(cur_norm_nxt);
      corner_rec.first_pos_index = to_out(first_pos_nxt);
      corner_rec.corner_count    = to_cc(corners_nxt);
      corner_rec.last            = 1'b0;
      cur_pos_nxt  = '0;
      cur_tex_nxt  = '0;
      cur_norm_nxt = '0;
      phase_nxt    = PH_POS_WAIT;
      run_pw       = 1'b1;
    end

    if (run_pw) begin
      if (is_nl) begin
        do_end = 1'b1;
      end else if (is_sign || is_dig) begin
        neg_nxt   = (char_in == CH_MINUS);
        seen_nxt  = is_dig;
        accum_nxt = is_dig ? dig_val : '0;
        phase_nxt = PH_POS_NUM;
      end else if (!is_blank) begin
        do_fail = 1'b1;
      end
    end

    if (do_fail) begin
      err_nxt   = 1'b1;
      phase_nxt = PH_ERR;
      do_end    = is_nl;
    end

    if (do_end) begin
      end_rec.kind            = err_nxt ? KIND_END_ERR : KIND_END_OK;
      end_rec.first_pos_index = to_out(first_pos_nxt);
      end_rec.corner_count    = to_cc(corners_nxt);
      end_rec.last            = 1'b1;
      phase_nxt     = PH_POS_WAIT;
      accum_nxt     = '0;
      neg_nxt       = 1'b0;
      seen_nxt      = 1'b0;
      cur_pos_nxt   = '0;
      cur_tex_nxt   = '0;
      cur_norm_nxt  = '0;
      first_pos_nxt = '0;
      corners_nxt   = '0;
      err_nxt       = 1'b0;
    end
  end

  assign rec0      = corner_done ? corner_rec : end_rec;
  assign rec1      = end_rec;
  assign push.rec0 = accept && (corner_done || do_end);
  assign push.rec1 = accept && corner_done && do_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_POS_WAIT;
      accum_r     <= '0;
      neg_r       <= 1'b0;
      seen_r      <= 1'b0;
      cur_pos_r   <= '0;
      cur_tex_r   <= '0;
      cur_norm_r  <= '0;
      first_pos_r <= '0;
      corners_r   <= '0;
      err_r       <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
      neg_r       <= neg_nxt;
      seen_r      <= seen_nxt;
      cur_pos_r   <= cur_pos_nxt;
      cur_tex_r   <= cur_tex_nxt;
      cur_norm_r  <= cur_norm_nxt;
      first_pos_r <= first_pos_nxt;
      corners_r   <= corners_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule

// ----- src/ofip_res_fifo.sv -----
// Four-entry result queue taking up to two records per cycle and giving one while the sink is ready.
module ofip_res_fifo import ofip_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  res_t  rec0,
  input  res_t  rec1,
  input  logic  pop_ready,
  output logic  head_valid,
  output res_t  head,
  output logic  space_ok
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [CNT_W-1:0] n_push;

  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_ptr_r];
  // Leave room for the two records one character can produce.
  assign space_ok   = (32'(cnt_r) <= DEPTH - 2);
  assign pop        = head_valid && pop_ready;
  assign wr_ptr_inc = wr_ptr_r + 1'b1;
  assign n_push     = CNT_W'(push.rec0) + CNT_W'(push.rec1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.rec0) mem[wr_ptr_r]   <= rec0;
    if (push.rec1) mem[wr_ptr_inc] <= rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- src/obj_face_index_parser.sv -----
// OBJ face line parser: one character per transaction in, corner and face-end
// records out. One character is taken every cycle while in_ch.ready is high;
// its records are written into a four-entry result queue at the same edge and
// show on the output from the next cycle at the earliest. A character that
// finishes a corner and also ends the face (a newline right after a corner)
// yields two records, delivered in turn. in_ch.ready drops while the queue
// holds three or more records, so the sink's draining sets the input rate.
module obj_face_index_parser import ofip_pkg::*; #(
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ofip_in_if.sink   in_ch,
  ofip_out_if.source out_ch
);

  logic  accept;
  logic  space_ok;
  logic  head_valid;
  res_t  rec0, rec1, head;
  push_t push;

  assign in_ch.ready = space_ok;
  assign accept      = in_ch.valid && space_ok;

  ofip_parse #(
    .INDEX_BITS  (INDEX_BITS),
    .MAX_CORNERS (MAX_CORNERS)
  ) u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .char_in        (in_ch.char_in),
    .position_count (in_ch.position_count),
    .texcoord_count (in_ch.texcoord_count),
    .normal_count   (in_ch.normal_count),
    .rec0           (rec0),
    .rec1           (rec1),
    .push           (push)
  );

  ofip_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .rec0       (rec0),
    .rec1       (rec1),
    .pop_ready  (out_ch.ready),
    .head_valid (head_valid),
    .head       (head),
    .space_ok   (space_ok)
  );

  assign out_ch.valid           = head_valid;
  assign out_ch.kind            = head.kind;
  assign out_ch.pos_index       = head.pos_index;
  assign out_ch.tex_index       = head.tex_index;
  assign out_ch.norm_index      = head.norm_index;
  assign out_ch.first_pos_index = head.first_pos_index;
  assign out_ch.corner_count    = head.corner_count;
  assign out_ch.last            = head.last;

endmodule

// ----- src/ofip_checker.sv -----
// Port-level checks for the OBJ face index parser, bound to the top level.
module ofip_checker import ofip_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [CHAR_W-1:0]    in_char,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [KIND_W-1:0]    out_kind,
  input logic [OUT_IDX_W-1:0] out_pos,
  input logic [OUT_IDX_W-1:0] out_tex,
  input logic [OUT_IDX_W-1:0] out_norm,
  input logic [OUT_IDX_W-1:0] out_first_pos,
  input logic [CC_W-1:0]      out_corner_count,
  input logic                 out_last
);

  localparam logic [CHAR_W-1:0] CH_NL = 8'h0A;

  // Every newline closes the face, so a record is waiting next cycle.
  a_newline_gives_record: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_char == CH_NL |=> out_valid)
    else $error("newline accepted but no record pending");

  a_corner_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CORNER |-> out_corner_count != '0 && !out_last)
    else $error("corner record with zero count or last set");

  a_empty_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_corner_count == '0 |-> out_first_pos == '0)
    else $error("face without corners carries a first position");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_pos) &&
      $stable(out_tex) && $stable(out_norm) && $stable(out_first_pos) &&
      $stable(out_corner_count) && $stable(out_last))
    else $error("stalled record changed");

endmodule

bind obj_face_index_parser ofip_checker u_ofip_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_char          (in_ch.char_in),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_pos          (out_ch.pos_index),
  .out_tex          (out_ch.tex_index),
  .out_norm         (out_ch.norm_index),
  .out_first_pos    (out_ch.first_pos_index),
  .out_corner_count (out_ch.corner_count),
  .out_last         (out_ch.last)
);

// ----- tb/sv/tb_obj_face_index_parser.sv -----
// Self-checking testbench for the OBJ face index parser: directed and random face lines.
module tb_obj_face_index_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import ofip_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_CAP  = 100;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    SEEK_POS, READ_POS, AFTER_SLASH, READ_TEX, SEEK_NORM, READ_NORM, SKIP_LINE
  } parse_phase_t;

  logic clk;
  logic rst_n;

  ofip_in_if  in_ch ();
  ofip_out_if out_ch ();

  obj_face_index_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Parser shadow state
  parse_phase_t         phase;
  logic [COUNT_W-1:0]   num_acc;
  bit                   num_neg;
  bit                   num_has_digit;
  logic [OUT_IDX_W-1:0] pos_idx, tex_idx, norm_idx, first_idx;
  logic [CC_W-1:0]      corners_seen;
  bit                   face_bad;

  res_t pending_records[$];
  logic [7:0] line_buf[$];

  logic [COUNT_W-1:0] cnt_pos, cnt_tex, cnt_norm;
  bit traffic_gaps;
  bit count_jitter;

  int mismatches;
  int chars_sent;
  int lines_sent;
  int corner_recs;
  int end_recs;
  int bad_ends;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_sign_or_digit(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || is_digit(c);
  endfunction

  task append_char(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endtask

  task clear_face;
    phase         = SEEK_POS;
    num_acc       = '0;
    num_neg       = 1'b0;
    num_has_digit = 1'b0;
    pos_idx       = '0;
    tex_idx       = '0;
    norm_idx      = '0;
    first_idx     = '0;
    corners_seen  = '0;
    face_bad      = 1'b0;
  endtask

  task begin_num(input logic [7:0] c);
    num_neg       = (c == CH_MINUS);
    num_has_digit = is_digit(c);
    num_acc       = num_has_digit ? {16'd0, c - CH_ZERO} : '0;
  endtask

  task add_digit(input logic [7:0] c);
    num_acc = num_acc * 24'd10 + {16'd0, c - CH_ZERO};
  endtask

  // Zero stays zero, positive is one-based, negative counts back from the total.
  function automatic logic [OUT_IDX_W-1:0] resolved_index(input logic [COUNT_W-1:0] total);
    if (num_acc == '0)
      return '0;
    if (num_neg)
      return total - num_acc;
    return num_acc - 1'b1;
  endfunction

  task push_record(input logic [KIND_W-1:0] kind, input logic [OUT_IDX_W-1:0] p,
                   input logic [OUT_IDX_W-1:0] t, input logic [OUT_IDX_W-1:0] n,
                   input logic lst);
    res_t rec;
    rec.kind            = kind;
    rec.pos_index       = p;
    rec.tex_index       = t;
    rec.norm_index      = n;
    rec.first_pos_index = first_idx;
    rec.corner_count    = corners_seen;
    rec.last            = lst;
    pending_records.insert(pending_records.size(), rec);
  endtask

  task close_corner;
    if (corners_seen == '0)
      first_idx = pos_idx;
    if (corners_seen < CC_W'(MAX_CORNERS_DEF))
      corners_seen = corners_seen + 1'b1;
    push_record(KIND_CORNER, pos_idx, tex_idx, norm_idx, 1'b0);
    pos_idx  = '0;
    tex_idx  = '0;
    norm_idx = '0;
    phase    = SEEK_POS;
  endtask

  task close_face;
    push_record(face_bad ? KIND_END_ERR : KIND_END_OK, '0, '0, '0, 1'b1);
    clear_face();
  endtask

  task mark_bad(input logic [7:0] c);
    face_bad = 1'b1;
    phase    = SKIP_LINE;
    if (c == CH_NL)
      close_face();
  endtask

  task seek_pos(input logic [7:0] c);
    if (is_blank(c)) begin
    end else if (c == CH_NL) begin
      close_face();
    end else if (is_sign_or_digit(c)) begin
      begin_num(c);
      phase = READ_POS;
    end else begin
      mark_bad(c);
    end
  endtask

  // Advance the shadow parser by one character and queue the records it yields.
  task parse_face_char(input logic [7:0] c, input logic [COUNT_W-1:0] pc,
                       input logic [COUNT_W-1:0] tc, input logic [COUNT_W-1:0] nc);
    case (phase)
      SEEK_POS: seek_pos(c);
      READ_POS: begin
        if (is_digit(c)) begin
          add_digit(c);
          num_has_digit = 1'b1;
        end else if (!num_has_digit) begin
          mark_bad(c);
        end else begin
          pos_idx = resolved_index(pc);
          if (c == CH_SLASH) begin
            phase = AFTER_SLASH;
          end else begin
            close_corner();
            seek_pos(c);
          end
        end
      end
      AFTER_SLASH: begin
        if (is_digit(c)) begin
          begin_num(c);
          phase = READ_TEX;
        end else if (c == CH_SLASH) begin
          phase = SEEK_NORM;
        end else begin
          close_corner();
          seek_pos(c);
        end
      end
      READ_TEX: begin
        if (is_digit(c)) begin
          add_digit(c);
        end else begin
          tex_idx = resolved_index(tc);
          if (c == CH_SLASH) begin
            phase = SEEK_NORM;
          end else begin
            close_corner();
            seek_pos(c);
          end
        end
      end
      SEEK_NORM: begin
        if (is_blank(c)) begin
        end else if (is_sign_or_digit(c)) begin
          begin_num(c);
          phase = READ_NORM;
        end else begin
          mark_bad(c);
        end
      end
      READ_NORM: begin
        if (is_digit(c)) begin
          add_digit(c);
          num_has_digit = 1'b1;
        end else if (!num_has_digit) begin
          mark_bad(c);
        end else begin
          norm_idx = resolved_index(nc);
          close_corner();
          seek_pos(c);
        end
      end
      default: begin
        face_bad = 1'b1;
        if (c == CH_NL)
          close_face();
      end
    endcase
  endtask

  task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Check each output transaction, then predict from each input transaction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_records.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP)
            $display("%0t: unexpected record, kind %0d, none outstanding",
                     $time, out_ch.kind);
        end else begin
          want = pending_records.pop_front();
          if (want.kind == KIND_CORNER)
            corner_recs++;
          else
            end_recs++;
          if (want.kind == KIND_END_ERR)
            bad_ends++;
          check_field("kind", 32'(want.kind), 32'(out_ch.kind));
          check_field("pos_index", 32'(want.pos_index), 32'(out_ch.pos_index));
          check_field("tex_index", 32'(want.tex_index), 32'(out_ch.tex_index));
          check_field("norm_index", 32'(want.norm_index), 32'(out_ch.norm_index));
          check_field("first_pos_index", 32'(want.first_pos_index),
                      32'(out_ch.first_pos_index));
          check_field("corner_count", 32'(want.corner_count), 32'(out_ch.corner_count));
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
      if (in_ch.valid && in_ch.ready)
        parse_face_char(in_ch.char_in, in_ch.position_count, in_ch.texcoord_count,
                        in_ch.normal_count);
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!traffic_gaps)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return COUNT_W'($urandom_range(0, 64));
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  task pick_counts;
    cnt_pos  = pick_count();
    cnt_tex  = pick_count();
    cnt_norm = pick_count();
  endtask

  initial begin
    int run;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run = $urandom_range(1, 20);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d records outstanding",
             cycle_count, pending_records.size());
    $display("Mismatches found");
    $finish;
  end

  task send_char(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (count_jitter && $urandom_range(0, 15) == 0)
      pick_counts();
    in_ch.valid          <= 1'b1;
    in_ch.char_in        <= c;
    in_ch.position_count <= cnt_pos;
    in_ch.texcoord_count <= cnt_tex;
    in_ch.normal_count   <= cnt_norm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
    if (c == CH_NL)
      lines_sent++;
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  task add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      append_char(s[i]);
  endtask

  task flush_line;
    while (line_buf.size() != 0)
      send_char(line_buf.pop_front());
  endtask

  // Hold the sender until every outstanding record has been delivered.
  task wait_for_drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  task add_blanks(input int n);
    for (int i = 0; i < n; i++)
      case ($urandom_range(0, 7))
        0: append_char(8'h09);
        1: append_char(8'h0D);
        2: append_char(8'h0B);
        3: append_char(8'h0C);
        default: append_char(CH_SPACE);
      endcase
  endtask

  task add_number(input bit signed_ok);
    int r;
    int unsigned v;
    if (signed_ok)
      case ($urandom_range(0, 9))
        0, 1: append_char(CH_MINUS);
        2: append_char(CH_PLUS);
        default: ;
      endcase
    if ($urandom_range(0, 9) == 0)
      append_char(CH_ZERO);
    r = $urandom_range(0, 99);
    if (r < 5)
      v = 0;
    else if (r < 75)
      v = $urandom_range(1, 999);
    else if (r < 93)
      v = $urandom_range(1000, 99999);
    else
      v = $urandom;
    add_text($sformatf("%0d", v));
  endtask

  task add_corner;
    int form;
    form = $urandom_range(0, 4);
    add_number(1'b1);
    case (form)
      1: begin
        append_char(CH_SLASH);
        add_number(1'b0);
      end
      2: begin
        append_char(CH_SLASH);
        add_number(1'b0);
        append_char(CH_SLASH);
        if ($urandom_range(0, 9) == 0)
          add_blanks($urandom_range(1, 2));
        add_number(1'b1);
      end
      3: begin
        append_char(CH_SLASH);
        append_char(CH_SLASH);
        if ($urandom_range(0, 9) == 0)
          add_blanks($urandom_range(1, 2));
        add_number(1'b1);
      end
      4: append_char(CH_SLASH);
      default: ;
    endcase
  endtask

  // Mostly well-formed lines; the rest mix corners with stray bytes.
  task build_random_face;
    int r;
    int n;
    pick_counts();
    r = $urandom_range(0, 99);
    n = (r < 4) ? 0 : $urandom_range(1, 6);
    if (r < 82) begin
      for (int i = 0; i < n; i++) begin
        if (i > 0 || $urandom_range(0, 1) == 1)
          add_blanks($urandom_range(1, 2));
        add_corner();
      end
      if ($urandom_range(0, 3) == 0)
        add_blanks($urandom_range(1, 3));
    end else begin
      for (int i = 0; i < n; i++)
        case ($urandom_range(0, 3))
          0: add_corner();
          1: append_char(8'($urandom_range(0, 255)));
          2: case ($urandom_range(0, 2))
               0: append_char(CH_SLASH);
               1: append_char(CH_PLUS);
               default: append_char(CH_MINUS);
             endcase
          default: add_blanks(1);
        endcase
    end
    append_char(CH_NL);
  endtask

  task test_plain_corners;
    traffic_gaps = 1'b1;
    cnt_pos = 24'd10; cnt_tex = 24'd10; cnt_norm = 24'd10;
    send_text("1 2 3\n");
    send_text(" 1/2/3 4/5/6\t7/8/9\n");
    send_text("1//3 2//4\n");
    send_text("1/2 3/4 5/\n");
  endtask

  task test_signed_indices;
    cnt_pos = '0; cnt_tex = '0; cnt_norm = '0;
    send_text("-1 -2/-3/-4 +5//+6\n");
    cnt_pos = '1; cnt_tex = '1; cnt_norm = '1;
    send_text("-1/-16777215/-7 0 0/0/0\n");
    wait_for_drain();
  endtask

  task test_number_wrap;
    cnt_pos = 24'd100; cnt_tex = 24'd7; cnt_norm = 24'h800000;
    send_text("16777216 16777217/99999999999/4294967296\n");
    send_text("+16777215 -16777216 0007/-0/-16777217\n");
  endtask

  task test_separators;
    cnt_pos = 24'd50; cnt_tex = 24'd40; cnt_norm = 24'd30;
    send_text("1-2+3 4/-5 6/7-8\n");
    send_text("\t\0151 2// \t 3\013\014\n");
    send_text("1/ 2/\t3 4/5/ 6\n");
  endtask

  task test_malformed_faces;
    cnt_pos = 24'd20; cnt_tex = 24'd20; cnt_norm = 24'd20;
    send_text("x 1 2\n");
    send_text("-\n");
    send_text("1 + 2\n");
    send_text("1//\n");
    send_text("1//-\n");
    send_text("1/2/x 3\n");
    send_text("1 2 /3\n");
    send_text("1 \377 2\n");
  endtask

  task test_empty_faces;
    send_text("\n");
    send_text("  \t\n");
    send_text("5\n");
  endtask

  // Single-digit corners with one-byte separators push the count past its cap.
  task test_corner_saturation;
    pick_counts();
    for (int i = 0; i < 258; i++) begin
      append_char(8'(8'h31 + $urandom_range(0, 8)));
      case ($urandom_range(0, 2))
        0: append_char(CH_SPACE);
        1: append_char(CH_PLUS);
        default: append_char(CH_MINUS);
      endcase
    end
    append_char(CH_NL);
    flush_line();
  endtask

  task test_random_faces(input int budget);
    int start;
    int face_no;
    start = chars_sent;
    face_no = 0;
    count_jitter = 1'b1;
    while (chars_sent - start < budget) begin
      traffic_gaps = ($urandom_range(0, 5) != 0);
      if (face_no % 30 == 15)
        wait_for_drain();
      build_random_face();
      flush_line();
      face_no++;
    end
    count_jitter = 1'b0;
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.char_in        <= '0;
    in_ch.position_count <= '0;
    in_ch.texcoord_count <= '0;
    in_ch.normal_count   <= '0;
    traffic_gaps = 1'b1;
    count_jitter = 1'b0;
    cnt_pos = '0; cnt_tex = '0; cnt_norm = '0;
    clear_face();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_corners();
    test_signed_indices();
    test_number_wrap();
    test_separators();
    test_malformed_faces();
    test_empty_faces();
    test_corner_saturation();
    test_random_faces(100);

    in_ch.valid <= 1'b0;
    traffic_gaps = 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Drove %0d characters over %0d face lines with random gaps on both sides.",
             chars_sent, lines_sent);
    $display("Checked %0d corner records and %0d face ends, %0d of them flagged bad.",
             corner_recs, end_recs, bad_ends);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
